>>> rtl/nvme_queue_pair_tracker_macros.svh
// assertion macros used by the queue pair tracker checker
`ifndef NVME_QUEUE_PAIR_TRACKER_MACROS_SVH
`define NVME_QUEUE_PAIR_TRACKER_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define NQPT_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define NQPT_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/nqpt_pkg.sv
// shared types, codes and constants of the queue pair tracker
package nqpt_pkg;

   // fixed field widths
   localparam int ID_W      = 16;
   localparam int STATUS_W  = 15;
   localparam int FIELD_W   = 6;
   localparam int QSIZE_W   = 7;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_QUEUE_SIZE = 1'b0;
   localparam logic [QSIZE_W-1:0] QSIZE_RESET = 7'd64;

   // command queue between front and back
   localparam int CMD_Q_DEPTH = 2;
   localparam int CMD_Q_PTR_W = $clog2(CMD_Q_DEPTH);
   localparam int CMD_Q_CNT_W = $clog2(CMD_Q_DEPTH + 1);

   // action codes
   localparam logic [1:0] ACT_SUBMIT_TRACKED   = 2'd0;
   localparam logic [1:0] ACT_SUBMIT_UNTRACKED = 2'd1;
   localparam logic [1:0] ACT_COMPLETION       = 2'd2;

   // outcome codes
   localparam logic [2:0] OUT_SUBMITTED    = 3'd0;
   localparam logic [2:0] OUT_RING_FULL    = 3'd1;
   localparam logic [2:0] OUT_PENDING_FULL = 3'd2;
   localparam logic [2:0] OUT_MATCHED      = 3'd3;
   localparam logic [2:0] OUT_UNMATCHED    = 3'd4;
   localparam logic [2:0] OUT_NOT_NEW      = 3'd5;

   typedef struct packed {
      logic [1:0]          action;
      logic                cqe_phase;
      logic [ID_W-1:0]     cqe_command_id;
      logic [STATUS_W-1:0] cqe_status;
   } req_data_type;

   typedef struct packed {
      logic [2:0]          outcome;
      logic [FIELD_W-1:0]  slot_index;
      logic [ID_W-1:0]     command_id;
      logic [FIELD_W-1:0]  tail_doorbell;
      logic [FIELD_W-1:0]  head_doorbell;
      logic [STATUS_W-1:0] completion_status;
   } rsp_data_type;

   // classified operation handed from front to back
   typedef enum logic [1:0] {
      OP_SUBMIT_TRACKED,
      OP_SUBMIT_UNTRACKED,
      OP_COMPLETE,
      OP_IGNORE
   } op_type;

   typedef struct packed {
      op_type              op;
      logic                cqe_phase;
      logic [ID_W-1:0]     cid;
      logic [STATUS_W-1:0] status;
   } cmd_type;

   // handshake between command queue and back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_beat_type;

endpackage

>>> rtl/nqpt_ram.sv
// generic single-write, single-read ram with registered read data
module nqpt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/nqpt_front.sv
// front end: takes request beats and classifies them into commands
module nqpt_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  nqpt_pkg::req_data_type req_data,
   output logic                  push_valid,
   output nqpt_pkg::cmd_type     push_cmd,
   input  logic                  push_full
);

   logic              cmd_valid_ff;
   logic              cmd_valid_in;
   nqpt_pkg::cmd_type cmd_data_ff;
   nqpt_pkg::cmd_type cmd_data_in;
   logic              accept;
   logic              take;

   // stage drains into the queue when it has room
   assign take      = cmd_valid_ff && !push_full;
   assign req_stall = cmd_valid_ff && push_full;
   assign accept    = req_valid && !req_stall;

   // decode the action into an operation
   always_comb begin
      cmd_data_in           = cmd_data_ff;
      cmd_valid_in          = cmd_valid_ff;
      if (take) begin
         cmd_valid_in = 1'b0;
      end
      if (accept) begin
         cmd_valid_in          = 1'b1;
         cmd_data_in.cqe_phase = req_data.cqe_phase;
         cmd_data_in.cid       = req_data.cqe_command_id;
         cmd_data_in.status    = req_data.cqe_status;
         case (req_data.action)
            nqpt_pkg::ACT_SUBMIT_TRACKED: begin
               cmd_data_in.op = nqpt_pkg::OP_SUBMIT_TRACKED;
            end
            nqpt_pkg::ACT_SUBMIT_UNTRACKED: begin
               cmd_data_in.op = nqpt_pkg::OP_SUBMIT_UNTRACKED;
            end
            nqpt_pkg::ACT_COMPLETION: begin
               cmd_data_in.op = nqpt_pkg::OP_COMPLETE;
            end
            default: begin
               cmd_data_in.op = nqpt_pkg::OP_IGNORE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
      cmd_data_ff <= cmd_data_in;
   end

   assign push_valid = cmd_valid_ff;
   assign push_cmd   = cmd_data_ff;

endmodule

>>> rtl/nqpt_cmd_queue.sv
// short command queue between the front and back ends
module nqpt_cmd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  nqpt_pkg::cmd_type         push_cmd,
   output logic                      push_full,
   output nqpt_pkg::cmd_beat_type    head,
   input  logic                      pop
);

   localparam logic [nqpt_pkg::CMD_Q_PTR_W-1:0] LAST_PTR =
      nqpt_pkg::CMD_Q_PTR_W'(nqpt_pkg::CMD_Q_DEPTH - 1);
   localparam logic [nqpt_pkg::CMD_Q_CNT_W-1:0] FULL_CNT =
      nqpt_pkg::CMD_Q_CNT_W'(nqpt_pkg::CMD_Q_DEPTH);

   nqpt_pkg::cmd_type                  slots_ff [nqpt_pkg::CMD_Q_DEPTH];
   logic [nqpt_pkg::CMD_Q_PTR_W-1:0]   wr_ptr_ff;
   logic [nqpt_pkg::CMD_Q_PTR_W-1:0]   wr_ptr_in;
   logic [nqpt_pkg::CMD_Q_PTR_W-1:0]   rd_ptr_ff;
   logic [nqpt_pkg::CMD_Q_PTR_W-1:0]   rd_ptr_in;
   logic [nqpt_pkg::CMD_Q_CNT_W-1:0]   count_ff;
   logic [nqpt_pkg::CMD_Q_CNT_W-1:0]   count_in;
   logic                               do_push;
   logic                               do_pop;

   assign push_full  = (count_ff == FULL_CNT);
   assign head.valid = (count_ff != '0);
   assign head.cmd   = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && !push_full;
   assign do_pop     = pop && head.valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/nqpt_back.sv
// back end: ring pointers, pending id table and result register
module nqpt_back #(
   parameter int QUEUE_DEPTH   = 64,
   parameter int PENDING_DEPTH = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [nqpt_pkg::QSIZE_W-1:0]      queue_size,
   input  nqpt_pkg::cmd_beat_type            head,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output nqpt_pkg::rsp_data_type            rsp_data
);

   localparam int PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int SIZE_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int PIDX_W    = $clog2(PENDING_DEPTH);
   localparam int PCNT_W    = $clog2(PENDING_DEPTH + 1);
   localparam int DCNT_W    = $clog2(SIZE_W + 1);
   localparam logic [SIZE_W-1:0] DEPTH_SIZE = SIZE_W'(QUEUE_DEPTH);
   localparam logic [SIZE_W-1:0] MIN_SIZE   = SIZE_W'(2);
   localparam logic [PIDX_W-1:0] LAST_PIDX  = PIDX_W'(PENDING_DEPTH - 1);
   localparam logic [PCNT_W-1:0] FULL_COUNT = PCNT_W'(PENDING_DEPTH);
   localparam logic [DCNT_W-1:0] LAST_STEP  = DCNT_W'(SIZE_W - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WRAP,
      ST_SUBMIT,
      ST_SCAN
   } state_type;

   // pointer to a 6-bit doorbell field
   function automatic logic [nqpt_pkg::FIELD_W-1:0] to_field(input logic [PTR_W-1:0] v);
      logic [PTR_W+nqpt_pkg::FIELD_W-1:0] w;
      w = {{nqpt_pkg::FIELD_W{1'b0}}, v};
      return w[nqpt_pkg::FIELD_W-1:0];
   endfunction

   state_type                     state_ff, state_in;
   logic [PTR_W-1:0]              sq_tail_ff, sq_tail_in;
   logic [PTR_W-1:0]              cq_head_ff, cq_head_in;
   logic                          phase_ff, phase_in;
   logic [nqpt_pkg::ID_W-1:0]     next_id_ff, next_id_in;
   logic [PCNT_W-1:0]             pend_cnt_ff, pend_cnt_in;
   logic [PIDX_W-1:0]             alloc_ptr_ff, alloc_ptr_in;
   logic [PENDING_DEPTH-1:0]      pend_vld_ff, pend_vld_in;
   nqpt_pkg::cmd_type             cmd_ff, cmd_in;
   logic [PTR_W-1:0]              next_tail_ff, next_tail_in;
   logic [SIZE_W-1:0]             div_rem_ff, div_rem_in;
   logic [SIZE_W-1:0]             div_num_ff, div_num_in;
   logic [DCNT_W-1:0]             div_cnt_ff, div_cnt_in;
   logic [PIDX_W-1:0]             scan_addr_ff, scan_addr_in;
   logic                          scan_issue_ff, scan_issue_in;
   logic                          chk_vld_ff, chk_vld_in;
   logic [PIDX_W-1:0]             chk_idx_ff, chk_idx_in;
   logic                          hit_ff, hit_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   nqpt_pkg::rsp_data_type        rsp_data_ff, rsp_data_in;

   logic                          ram_we;
   logic [nqpt_pkg::ID_W-1:0]     ram_rdata;
   logic [SIZE_W-1:0]             eff_size;
   logic [31:0]                   qs_wide;

   // pending id storage
   nqpt_ram #(
      .WIDTH (nqpt_pkg::ID_W),
      .DEPTH (PENDING_DEPTH)
   ) u_pend_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (alloc_ptr_ff),
      .wr_data (next_id_ff),
      .rd_addr (scan_addr_ff),
      .rd_data (ram_rdata)
   );

   // ring size clamped to the supported range
   always_comb begin
      qs_wide = 32'(queue_size);
      if (qs_wide < 32'd2) begin
         eff_size = MIN_SIZE;
      end else if (qs_wide > 32'(QUEUE_DEPTH)) begin
         eff_size = DEPTH_SIZE;
      end else begin
         eff_size = SIZE_W'(qs_wide);
      end
   end

   // sequencer
   always_comb begin
      logic                    out_free;
      logic                    load;
      nqpt_pkg::rsp_data_type  rsp_next;
      logic [SIZE_W-1:0]       tail_inc;
      logic [SIZE_W-1:0]       head_inc;
      logic [PTR_W-1:0]        new_head;
      logic [SIZE_W:0]         shifted;
      logic [SIZE_W-1:0]       rem_next;
      logic                    match;
      logic                    hit_now;

      state_in      = state_ff;
      sq_tail_in    = sq_tail_ff;
      cq_head_in    = cq_head_ff;
      phase_in      = phase_ff;
      next_id_in    = next_id_ff;
      pend_cnt_in   = pend_cnt_ff;
      alloc_ptr_in  = alloc_ptr_ff;
      pend_vld_in   = pend_vld_ff;
      cmd_in        = cmd_ff;
      next_tail_in  = next_tail_ff;
      div_rem_in    = div_rem_ff;
      div_num_in    = div_num_ff;
      div_cnt_in    = div_cnt_ff;
      scan_addr_in  = scan_addr_ff;
      scan_issue_in = scan_issue_ff;
      chk_vld_in    = chk_vld_ff;
      chk_idx_in    = chk_idx_ff;
      hit_in        = hit_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      pop           = 1'b0;
      load          = 1'b0;
      rsp_next      = '0;
      match         = 1'b0;
      hit_now       = hit_ff;
      new_head      = cq_head_ff;

      out_free = !rsp_valid_ff || !rsp_stall;
      tail_inc = SIZE_W'(sq_tail_ff) + SIZE_W'(1);
      head_inc = SIZE_W'(cq_head_ff) + SIZE_W'(1);
      shifted  = {div_rem_ff, div_num_ff[SIZE_W-1]};
      rem_next = shifted[SIZE_W-1:0];
      if (shifted >= {1'b0, eff_size}) begin
         rem_next = SIZE_W'(shifted - {1'b0, eff_size});
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         // take one command and settle the quick cases
         ST_IDLE: begin
            if (head.valid && out_free) begin
               pop    = 1'b1;
               cmd_in = head.cmd;
               case (head.cmd.op)
                  nqpt_pkg::OP_SUBMIT_TRACKED, nqpt_pkg::OP_SUBMIT_UNTRACKED: begin
                     if (tail_inc < eff_size) begin
                        next_tail_in = tail_inc[PTR_W-1:0];
                        state_in     = ST_SUBMIT;
                     end else if (tail_inc == eff_size) begin
                        next_tail_in = '0;
                        state_in     = ST_SUBMIT;
                     end else begin
                        // tail beyond a shrunken ring: reduce by long division
                        div_num_in = tail_inc;
                        div_rem_in = '0;
                        div_cnt_in = '0;
                        state_in   = ST_WRAP;
                     end
                  end
                  nqpt_pkg::OP_COMPLETE: begin
                     rsp_next.command_id = head.cmd.cid;
                     if ((head.cmd.cqe_phase == phase_ff) || (cq_head_ff == sq_tail_ff)) begin
                        rsp_next.outcome       = nqpt_pkg::OUT_NOT_NEW;
                        rsp_next.head_doorbell = to_field(cq_head_ff);
                        load                   = 1'b1;
                     end else begin
                        if (head_inc >= eff_size) begin
                           new_head = '0;
                           phase_in = !phase_ff;
                        end else begin
                           new_head = head_inc[PTR_W-1:0];
                        end
                        cq_head_in = new_head;
                        if (pend_cnt_ff == '0) begin
                           rsp_next.outcome       = nqpt_pkg::OUT_UNMATCHED;
                           rsp_next.head_doorbell = to_field(new_head);
                           load                   = 1'b1;
                        end else begin
                           hit_in        = 1'b0;
                           scan_addr_in  = '0;
                           scan_issue_in = 1'b1;
                           chk_vld_in    = 1'b0;
                           state_in      = ST_SCAN;
                        end
                     end
                  end
                  default: begin
                     rsp_next.outcome = nqpt_pkg::OUT_NOT_NEW;
                     load             = 1'b1;
                  end
               endcase
            end
         end

         // one remainder bit per cycle
         ST_WRAP: begin
            div_rem_in = rem_next;
            div_num_in = div_num_ff << 1;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == LAST_STEP) begin
               next_tail_in = rem_next[PTR_W-1:0];
               state_in     = ST_SUBMIT;
            end
         end

         // ring and table checks, free slot search, commit
         ST_SUBMIT: begin
            if (cq_head_ff == next_tail_ff) begin
               rsp_next.outcome = nqpt_pkg::OUT_RING_FULL;
               load             = 1'b1;
               state_in         = ST_IDLE;
            end else if ((cmd_ff.op == nqpt_pkg::OP_SUBMIT_TRACKED) &&
                         (pend_cnt_ff == FULL_COUNT)) begin
               rsp_next.outcome = nqpt_pkg::OUT_PENDING_FULL;
               load             = 1'b1;
               state_in         = ST_IDLE;
            end else if ((cmd_ff.op == nqpt_pkg::OP_SUBMIT_TRACKED) &&
                         pend_vld_ff[alloc_ptr_ff]) begin
               alloc_ptr_in = (alloc_ptr_ff == LAST_PIDX) ? '0 : alloc_ptr_ff + PIDX_W'(1);
            end else begin
               if (cmd_ff.op == nqpt_pkg::OP_SUBMIT_TRACKED) begin
                  ram_we                    = 1'b1;
                  pend_vld_in[alloc_ptr_ff] = 1'b1;
                  pend_cnt_in               = pend_cnt_ff + PCNT_W'(1);
                  alloc_ptr_in = (alloc_ptr_ff == LAST_PIDX) ? '0 : alloc_ptr_ff + PIDX_W'(1);
               end
               rsp_next.outcome       = nqpt_pkg::OUT_SUBMITTED;
               rsp_next.slot_index    = to_field(sq_tail_ff);
               rsp_next.command_id    = next_id_ff;
               rsp_next.tail_doorbell = to_field(next_tail_ff);
               sq_tail_in             = next_tail_ff;
               next_id_in             = next_id_ff + 1'b1;
               load                   = 1'b1;
               state_in               = ST_IDLE;
            end
         end

         // walk the pending table: issue a read, compare its data in the following cycle
         ST_SCAN: begin
            chk_vld_in = scan_issue_ff;
            chk_idx_in = scan_addr_ff;
            if (scan_issue_ff) begin
               if (scan_addr_ff == LAST_PIDX) begin
                  scan_issue_in = 1'b0;
               end else begin
                  scan_addr_in = scan_addr_ff + PIDX_W'(1);
               end
            end
            if (chk_vld_ff) begin
               match = pend_vld_ff[chk_idx_ff] && (ram_rdata == cmd_ff.cid);
               if (match) begin
                  pend_vld_in[chk_idx_ff] = 1'b0;
                  pend_cnt_in             = pend_cnt_ff - PCNT_W'(1);
               end
               hit_now = hit_ff || match;
               hit_in  = hit_now;
               if (chk_idx_ff == LAST_PIDX) begin
                  rsp_next.outcome       = hit_now ? nqpt_pkg::OUT_MATCHED
                                                   : nqpt_pkg::OUT_UNMATCHED;
                  rsp_next.command_id    = cmd_ff.cid;
                  rsp_next.head_doorbell = to_field(cq_head_ff);
                  rsp_next.completion_status = hit_now ? cmd_ff.status : '0;
                  load       = 1'b1;
                  chk_vld_in = 1'b0;
                  state_in   = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sq_tail_ff    <= '0;
         cq_head_ff    <= '0;
         phase_ff      <= 1'b0;
         next_id_ff    <= '0;
         pend_cnt_ff   <= '0;
         alloc_ptr_ff  <= '0;
         pend_vld_ff   <= '0;
         scan_issue_ff <= 1'b0;
         chk_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sq_tail_ff    <= sq_tail_in;
         cq_head_ff    <= cq_head_in;
         phase_ff      <= phase_in;
         next_id_ff    <= next_id_in;
         pend_cnt_ff   <= pend_cnt_in;
         alloc_ptr_ff  <= alloc_ptr_in;
         pend_vld_ff   <= pend_vld_in;
         scan_issue_ff <= scan_issue_in;
         chk_vld_ff    <= chk_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      next_tail_ff <= next_tail_in;
      div_rem_ff   <= div_rem_in;
      div_num_ff   <= div_num_in;
      div_cnt_ff   <= div_cnt_in;
      scan_addr_ff <= scan_addr_in;
      chk_idx_ff   <= chk_idx_in;
      hit_ff       <= hit_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/nvme_queue_pair_tracker.sv
// top level: queue pair tracker with its configuration register
// a submit result waits for the remainder steps when the tail lies beyond a shrunken
//   ring, and for each taken slot skipped; the back end handles one command at a time,
//   and a completion with pending ids walks the whole pending id memory
// reset: synchronous; clears pointers, phase, id counter and pending valid flags,
//   sets queue_size to 64; no clearing pass
module nvme_queue_pair_tracker #(
   parameter int QUEUE_DEPTH   = 64,
   parameter int PENDING_DEPTH = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  nqpt_pkg::req_data_type              req_data,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output nqpt_pkg::rsp_data_type              rsp_data,
   // register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [nqpt_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [nqpt_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [nqpt_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   logic [nqpt_pkg::QSIZE_W-1:0] queue_size_ff;
   logic [nqpt_pkg::QSIZE_W-1:0] queue_size_in;
   logic                         reg_hit;
   logic                         push_valid;
   nqpt_pkg::cmd_type            push_cmd;
   logic                         push_full;
   nqpt_pkg::cmd_beat_type       q_head;
   logic                         q_pop;

   // register decode
   assign pready  = 1'b1;
   assign reg_hit = (paddr[2] == nqpt_pkg::REG_QUEUE_SIZE);

   always_comb begin
      queue_size_in = queue_size_ff;
      if (psel && penable && pwrite && pready && reg_hit) begin
         queue_size_in = pwdata[nqpt_pkg::QSIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         queue_size_ff <= nqpt_pkg::QSIZE_RESET;
      end else begin
         queue_size_ff <= queue_size_in;
      end
   end

   // read back
   assign prdata = reg_hit ? nqpt_pkg::CSR_DATA_W'(queue_size_ff) : '0;

   nqpt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_full  (push_full)
   );

   nqpt_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_full  (push_full),
      .head       (q_head),
      .pop        (q_pop)
   );

   nqpt_back #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .PENDING_DEPTH (PENDING_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .queue_size (queue_size_ff),
      .head       (q_head),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

>>> rtl/nqpt_checker.sv
// port-level checks for the queue pair tracker, bound to the top level
`include "nvme_queue_pair_tracker_macros.svh"

module nqpt_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input nqpt_pkg::rsp_data_type rsp_data
);

   logic rsp_held;
   logic outcome_ok;
   logic refused;
   logic no_fields;
   logic status_set;
   logic is_matched;

   // conditions seen on the result port
   assign rsp_held   = rsp_valid && rsp_stall;
   assign outcome_ok = (rsp_data.outcome <= nqpt_pkg::OUT_NOT_NEW);
   assign refused    = rsp_valid && ((rsp_data.outcome == nqpt_pkg::OUT_RING_FULL) ||
                                     (rsp_data.outcome == nqpt_pkg::OUT_PENDING_FULL));
   assign no_fields  = (rsp_data.slot_index == '0) && (rsp_data.command_id == '0) &&
                       (rsp_data.tail_doorbell == '0) && (rsp_data.head_doorbell == '0);
   assign status_set = rsp_valid && (rsp_data.completion_status != '0);
   assign is_matched = (rsp_data.outcome == nqpt_pkg::OUT_MATCHED);

   // result beat holds while stalled
   `NQPT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid, "rsp dropped while stalled")
   `NQPT_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_held, $stable(rsp_data), "rsp data moved")

   // outcome code range
   `NQPT_ASSERT_IMPLY(a_outcome_range, clock, reset, rsp_valid, outcome_ok, "bad outcome code")

   // refused submits carry no slot, id or doorbell
   `NQPT_ASSERT_IMPLY(a_refused, clock, reset, refused, no_fields, "refused with fields")

   // status only accompanies a matched completion
   `NQPT_ASSERT_IMPLY(a_status_ok, clock, reset, status_set, is_matched, "status without match")

endmodule

bind nvme_queue_pair_tracker nqpt_checker u_nqpt_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> tb/testbench.sv
// testbench of the nvme queue pair tracker with its own prediction and random traffic
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH   = 64;
   localparam int PENDING_DEPTH = 128;
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam logic [nqpt_pkg::CSR_ADDR_W-1:0] ADDR_QUEUE_SIZE =
      nqpt_pkg::CSR_ADDR_W'(4 * int'(nqpt_pkg::REG_QUEUE_SIZE));
   localparam int IDLE_LIMIT    = 4000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 200;
   localparam int MATCH_PCT     = 70;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   nqpt_pkg::req_data_type          req_data = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   nqpt_pkg::rsp_data_type          rsp_data;
   logic                            psel = 1'b0;
   logic                            penable = 1'b0;
   logic                            pwrite = 1'b0;
   logic [nqpt_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [nqpt_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [nqpt_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   // predicted queue pair state
   logic [nqpt_pkg::QSIZE_W-1:0]  qp_size = nqpt_pkg::QSIZE_RESET;
   logic [nqpt_pkg::FIELD_W-1:0]  qp_tail = '0;
   logic [nqpt_pkg::FIELD_W-1:0]  qp_head = '0;
   logic                          qp_phase = 1'b0;
   logic [nqpt_pkg::ID_W-1:0]     qp_next_id = '0;
   logic [nqpt_pkg::ID_W-1:0]     qp_pend_id [PENDING_DEPTH];
   bit                            qp_pend_valid [PENDING_DEPTH];

   nqpt_pkg::rsp_data_type        queue_pair_results [$];
   int                            error_count = 0;
   int                            idle_pct = 0;
   int                            stall_pct = 0;
   int                            hold_req = 0;
   int                            hold_left = 0;
   int                            quiet_cycles = 0;

   nvme_queue_pair_tracker i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // pending table helpers
   function automatic int free_pending_entry();
      for (int i = 0; i < PENDING_DEPTH; i++) begin
         if (!qp_pend_valid[i]) return i;
      end
      return -1;
   endfunction

   function automatic int pending_entries();
      int n;
      n = 0;
      for (int i = 0; i < PENDING_DEPTH; i++) n += int'(qp_pend_valid[i]);
      return n;
   endfunction

   function automatic bit id_is_pending(logic [nqpt_pkg::ID_W-1:0] id);
      for (int i = 0; i < PENDING_DEPTH; i++) begin
         if (qp_pend_valid[i] && qp_pend_id[i] == id) return 1'b1;
      end
      return 1'b0;
   endfunction

   // next result and state update for one accepted beat
   function automatic nqpt_pkg::rsp_data_type predict_queue_pair(nqpt_pkg::req_data_type d);
      nqpt_pkg::rsp_data_type r;
      int size;
      int next_tail;
      int next_head;
      int slot;
      bit hit;
      r = '0;
      size = (qp_size < 2) ? 2 : ((qp_size > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(qp_size));
      case (d.action)
         nqpt_pkg::ACT_SUBMIT_TRACKED, nqpt_pkg::ACT_SUBMIT_UNTRACKED: begin
            next_tail = (int'(qp_tail) + 1) % size;
            slot = (d.action == nqpt_pkg::ACT_SUBMIT_TRACKED) ? free_pending_entry() : -1;
            if (int'(qp_head) == next_tail) begin
               r.outcome = nqpt_pkg::OUT_RING_FULL;
            end else if (d.action == nqpt_pkg::ACT_SUBMIT_TRACKED && slot < 0) begin
               r.outcome = nqpt_pkg::OUT_PENDING_FULL;
            end else begin
               if (slot >= 0) begin
                  qp_pend_id[slot] = qp_next_id;
                  qp_pend_valid[slot] = 1'b1;
               end
               r.outcome = nqpt_pkg::OUT_SUBMITTED;
               r.slot_index = qp_tail;
               r.command_id = qp_next_id;
               qp_next_id = qp_next_id + 1'b1;
               qp_tail = next_tail[nqpt_pkg::FIELD_W-1:0];
               r.tail_doorbell = qp_tail;
            end
         end
         nqpt_pkg::ACT_COMPLETION: begin
            r.command_id = d.cqe_command_id;
            if (d.cqe_phase == qp_phase || qp_head == qp_tail) begin
               r.outcome = nqpt_pkg::OUT_NOT_NEW;
            end else begin
               hit = 1'b0;
               for (int i = 0; i < PENDING_DEPTH; i++) begin
                  if (qp_pend_valid[i] && qp_pend_id[i] == d.cqe_command_id) begin
                     qp_pend_valid[i] = 1'b0;
                     hit = 1'b1;
                  end
               end
               r.outcome = hit ? nqpt_pkg::OUT_MATCHED : nqpt_pkg::OUT_UNMATCHED;
               if (hit) r.completion_status = d.cqe_status;
               // head wraps once it reaches or passes the ring size
               next_head = int'(qp_head) + 1;
               if (next_head >= size) begin
                  next_head = 0;
                  qp_phase = ~qp_phase;
               end
               qp_head = next_head[nqpt_pkg::FIELD_W-1:0];
            end
            r.head_doorbell = qp_head;
         end
         default: begin
            r.outcome = nqpt_pkg::OUT_NOT_NEW;
         end
      endcase
      return r;
   endfunction

   // beat builders
   function automatic nqpt_pkg::req_data_type make_item(logic [1:0] act, logic phase,
                                                        logic [nqpt_pkg::ID_W-1:0] cid,
                                                        logic [nqpt_pkg::STATUS_W-1:0] status);
      nqpt_pkg::req_data_type d;
      d.action = act;
      d.cqe_phase = phase;
      d.cqe_command_id = cid;
      d.cqe_status = status;
      return d;
   endfunction

   function automatic nqpt_pkg::req_data_type submit_item(logic [1:0] act);
      return make_item(act, 1'($urandom_range(1, 0)),
                       nqpt_pkg::ID_W'($urandom_range(16'hffff, 0)),
                       nqpt_pkg::STATUS_W'($urandom_range(15'h7fff, 0)));
   endfunction

   // completion entry, new or stale, carrying a pending id or one nobody waits for
   function automatic nqpt_pkg::req_data_type completion_item(bit fresh, bit match);
      logic [nqpt_pkg::ID_W-1:0] ids [$];
      logic [nqpt_pkg::ID_W-1:0] cid;
      for (int i = 0; i < PENDING_DEPTH; i++) begin
         if (qp_pend_valid[i]) ids.push_back(qp_pend_id[i]);
      end
      if (match && ids.size() != 0) begin
         cid = ids[$urandom_range(ids.size() - 1, 0)];
      end else begin
         do cid = nqpt_pkg::ID_W'($urandom_range(16'hffff, 0)); while (id_is_pending(cid));
      end
      return make_item(nqpt_pkg::ACT_COMPLETION, fresh ? ~qp_phase : qp_phase, cid,
                       nqpt_pkg::STATUS_W'($urandom_range(15'h7fff, 0)));
   endfunction

   function automatic nqpt_pkg::req_data_type random_item();
      int sel;
      sel = $urandom_range(99);
      if (sel < 40) return submit_item(nqpt_pkg::ACT_SUBMIT_TRACKED);
      if (sel < 60) return submit_item(nqpt_pkg::ACT_SUBMIT_UNTRACKED);
      if (sel < 95) return completion_item($urandom_range(99) < 85,
                                           $urandom_range(99) < MATCH_PCT);
      return submit_item(ACT_UNUSED);
   endfunction

   // send one request beat and record its prediction on acceptance
   task automatic send_item(nqpt_pkg::req_data_type d);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      queue_pair_results.push_back(predict_queue_pair(d));
   endtask

   task automatic wait_results_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (queue_pair_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register access: setup then access cycle
   task automatic csr_access(logic write, logic [nqpt_pkg::CSR_ADDR_W-1:0] addr,
                             logic [nqpt_pkg::CSR_DATA_W-1:0] value,
                             output logic [nqpt_pkg::CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= write;
      paddr <= addr;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      if (write && addr == ADDR_QUEUE_SIZE) qp_size = value[nqpt_pkg::QSIZE_W-1:0];
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic check_queue_size();
      logic [nqpt_pkg::CSR_DATA_W-1:0] rdata;
      csr_access(1'b0, ADDR_QUEUE_SIZE, '0, rdata);
      if (rdata[nqpt_pkg::QSIZE_W-1:0] !== qp_size) begin
         $error("queue_size readback: expected %0d, actual %0d", qp_size,
                rdata[nqpt_pkg::QSIZE_W-1:0]);
         error_count++;
      end
   endtask

   task automatic set_queue_size(int size);
      logic [nqpt_pkg::CSR_DATA_W-1:0] rdata;
      csr_access(1'b1, ADDR_QUEUE_SIZE, nqpt_pkg::CSR_DATA_W'(size), rdata);
      check_queue_size();
   endtask

   // compare one result beat with the oldest prediction
   task automatic check_result(nqpt_pkg::rsp_data_type got);
      nqpt_pkg::rsp_data_type want;
      if (queue_pair_results.size() == 0) begin
         $error("result beat with no prediction waiting: %h", got);
         error_count++;
      end else begin
         want = queue_pair_results.pop_front();
         if (got.outcome !== want.outcome) begin
            $error("outcome: expected %0d, actual %0d", want.outcome, got.outcome);
            error_count++;
         end
         if (got.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, actual %0d", want.slot_index, got.slot_index);
            error_count++;
         end
         if (got.command_id !== want.command_id) begin
            $error("command_id: expected %h, actual %h", want.command_id, got.command_id);
            error_count++;
         end
         if (got.tail_doorbell !== want.tail_doorbell) begin
            $error("tail_doorbell: expected %0d, actual %0d", want.tail_doorbell,
                   got.tail_doorbell);
            error_count++;
         end
         if (got.head_doorbell !== want.head_doorbell) begin
            $error("head_doorbell: expected %0d, actual %0d", want.head_doorbell,
                   got.head_doorbell);
            error_count++;
         end
         if (got.completion_status !== want.completion_status) begin
            $error("completion_status: expected %h, actual %h", want.completion_status,
                   got.completion_status);
            error_count++;
         end
      end
   endtask

   // result beats
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_result(rsp_data);
   end

   // receiver stall, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_req > 0) begin
         hold_left = hold_req;
         hold_req = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // each action from reset state, field extremes, ignored action code
   task automatic test_basic_actions();
      check_queue_size();
      send_item(make_item(nqpt_pkg::ACT_COMPLETION, 1'b1, '0, '0));   // empty ring: not new
      send_item(make_item(nqpt_pkg::ACT_SUBMIT_TRACKED, 1'b1, '1, '1));
      send_item(make_item(nqpt_pkg::ACT_SUBMIT_UNTRACKED, 1'b0, '0, '0));
      send_item(make_item(nqpt_pkg::ACT_COMPLETION, 1'b0, '0, '1));   // stale phase
      send_item(make_item(nqpt_pkg::ACT_COMPLETION, 1'b1, '0, '1));   // matches id 0
      send_item(make_item(nqpt_pkg::ACT_COMPLETION, 1'b1, '1, '0));   // nobody waits for ffff
      send_item(make_item(nqpt_pkg::ACT_COMPLETION, 1'b1, 16'h0001, 15'h5555));
      send_item(make_item(ACT_UNUSED, 1'b1, '1, '1));
      wait_results_drained();
   endtask

   // smallest ring, pointers left beyond a shrunken size, clamped register values
   task automatic test_queue_size_limits();
      set_queue_size(2);
      send_item(submit_item(nqpt_pkg::ACT_SUBMIT_TRACKED));
      send_item(submit_item(nqpt_pkg::ACT_SUBMIT_TRACKED));
      send_item(submit_item(nqpt_pkg::ACT_SUBMIT_UNTRACKED));
      repeat (3) send_item(completion_item(1'b1, 1'b1));
      wait_results_drained();
      set_queue_size(0);
      repeat (3) send_item(submit_item(nqpt_pkg::ACT_SUBMIT_UNTRACKED));
      send_item(completion_item(1'b1, 1'b0));
      wait_results_drained();
      set_queue_size(127);
      repeat (2) send_item(submit_item(nqpt_pkg::ACT_SUBMIT_TRACKED));
      send_item(completion_item(1'b1, 1'b1));
      wait_results_drained();
      set_queue_size(1);
      send_item(submit_item(nqpt_pkg::ACT_SUBMIT_UNTRACKED));
      wait_results_drained();
   endtask

   // fill the pending table with submits that no completion claims, then hit the full case
   task automatic test_pending_table_full();
      set_queue_size(64);
      while (pending_entries() < PENDING_DEPTH) begin
         send_item(submit_item(nqpt_pkg::ACT_SUBMIT_TRACKED));
         send_item(completion_item(1'b1, 1'b0));
      end
      repeat (2) send_item(submit_item(nqpt_pkg::ACT_SUBMIT_TRACKED));
      send_item(submit_item(nqpt_pkg::ACT_SUBMIT_UNTRACKED));
      send_item(completion_item(1'b1, 1'b1));
      send_item(submit_item(nqpt_pkg::ACT_SUBMIT_TRACKED));
      wait_results_drained();
   endtask

   // receiver holds off while requests keep coming, so the block backs up
   task automatic test_receiver_hold();
      idle_pct = 0;
      stall_pct = 0;
      hold_req = HOLD_CYCLES;
      repeat (16) send_item(random_item());
      wait_results_drained();
   endtask

   task automatic test_random_traffic(int size, int idle, int stall, int count);
      set_queue_size(size);
      idle_pct = idle;
      stall_pct = stall;
      repeat (count) send_item(random_item());
      wait_results_drained();
      idle_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_basic_actions();
      test_queue_size_limits();
      test_pending_table_full();
      test_receiver_hold();
      test_random_traffic(64, 0, 0, 30);
      test_random_traffic(2, 83, 0, 30);
      test_random_traffic(17, 0, 83, 30);
      test_random_traffic(64, 38, 38, 35);
      test_random_traffic(33, 0, 0, 30);
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
